// ===== hw/rtl/ghix_pkg.sv =====
// Package for the generalized Hilbert index-to-coordinate block.
// Holds shared constants, the controller state type and the command and status structs.
package ghix_pkg;

    localparam int CFG_BITS       = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int COORD_BITS_DEF = 12;
    localparam int INDEX_BITS_DEF = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK_A,
        ST_WALK_B,
        ST_OUT
    } ghix_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic walk_eval;
        logic walk_update;
    } ghix_cmd_t;

    typedef struct packed {
        logic div_last;
        logic walk_end;
    } ghix_status_t;

endpackage

// ===== hw/rtl/ghix_ctrl.sv =====
// Controller state machine for the generalized Hilbert index-to-coordinate block.
// Depends on ghix_pkg; drives the datapath through ghix_cmd_t.
module ghix_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ghix_pkg::ghix_status_t status,
    output ghix_pkg::ghix_cmd_t   cmd,
    output logic                  busy,
    output logic                  done
);
    import ghix_pkg::*;

    ghix_state_t state_reg;
    ghix_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_WALK_A;
                end
            end
            ST_WALK_A:
            begin
                cmd.walk_eval = 1'b1;
                state_next    = status.walk_end ? ST_OUT : ST_WALK_B;
            end
            ST_WALK_B:
            begin
                cmd.walk_update = 1'b1;
                state_next      = ST_WALK_A;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_OUT);

    // An accepted item always reaches the division phase first.
    a_start_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> state_reg == ST_DIV)
        else $error("accepted item did not enter division");

    // A result is only shown after the walk has reached its last rectangle.
    a_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(state_reg) == ST_WALK_A && $past(status.walk_end))
        else $error("result shown without finished walk");

    // The strobe lasts one cycle and the block is free right after it.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

endmodule

// ===== hw/rtl/ghix_datapath.sv =====
// Datapath for the generalized Hilbert index-to-coordinate block: restoring
// divider by the grid area and the rectangle-splitting walk. Depends on ghix_pkg.
module ghix_datapath #(
    parameter int COORD_BITS = ghix_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = ghix_pkg::INDEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ghix_pkg::ghix_cmd_t           cmd,
    output ghix_pkg::ghix_status_t        status,
    input  logic [ghix_pkg::CFG_BITS-1:0] grid_width,
    input  logic [ghix_pkg::CFG_BITS-1:0] grid_height,
    input  logic [INDEX_BITS-1:0]         task_index,
    output logic [INDEX_BITS-1:0]         outer_index,
    output logic [COORD_BITS-1:0]         m_coord,
    output logic [COORD_BITS-1:0]         n_coord
);
    import ghix_pkg::*;

    localparam int DW  = (COORD_BITS + 1 > CFG_BITS) ? COORD_BITS + 1 : CFG_BITS;
    localparam int MW  = COORD_BITS + 1;
    localparam int SW  = COORD_BITS + 3;
    localparam int PW  = 2 * COORD_BITS + 2;
    localparam int CNW = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;
    localparam logic [DW-1:0]  DIM_TOP  = DW'(1) << COORD_BITS;
    localparam logic [CNW-1:0] CNT_LAST = CNW'(INDEX_BITS - 1);

    function automatic logic [MW-1:0] clamp_dim(input logic [CFG_BITS-1:0] v);
        logic [DW-1:0] e;
        e = DW'(v);
        if (e == '0)
        begin
            return MW'(1);
        end
        else if (e > DIM_TOP)
        begin
            return MW'(DIM_TOP);
        end
        return MW'(e);
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] v);
        return v[SW-1] ? MW'(-v) : MW'(v);
    endfunction

    function automatic logic signed [SW-1:0] sgn(input logic signed [SW-1:0] v);
        if (v > 0)
        begin
            return SW'(1);
        end
        else if (v < 0)
        begin
            return -SW'(1);
        end
        return '0;
    endfunction

    // Divider state.
    logic [INDEX_BITS-1:0] quo_reg;
    logic [PW-1:0]         rem_reg;
    logic [PW-1:0]         area_reg;
    logic [CNW-1:0]        cnt_reg;

    // Walk state.
    logic signed [SW-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [SW-1:0] x_reg, y_reg;
    logic [PW-1:0]        cur_reg;
    logic signed [SW-1:0] ax2_reg, ay2_reg, bx2_reg, by2_reg;
    logic                 long_reg;
    logic [PW-1:0]        p1_reg, p2_reg;

    logic [MW-1:0] w_cl, h_cl;
    logic          along_w;
    logic [PW:0]   rem_shift;
    logic          rem_ge;

    logic signed [SW-1:0] sa, sb, sb2;
    logic [MW-1:0]        wv, hv, a2m, b2m;
    logic                 is_long;
    logic signed [SW-1:0] ax2, ay2, bx2, by2;
    logic [PW-1:0]        m1, m2, di;
    logic signed [SW-1:0] di_s;
    logic [PW:0]          p12;

    always_comb
    begin
        w_cl    = clamp_dim(grid_width);
        h_cl    = clamp_dim(grid_height);
        along_w = ((w_cl >= h_cl) && (!w_cl[0] || h_cl[0])) || !(w_cl[0] || !h_cl[0]);
        rem_shift = {rem_reg, quo_reg[INDEX_BITS-1]};
        rem_ge    = rem_shift >= {1'b0, area_reg};
    end

    always_comb
    begin
        sa      = ax_reg + ay_reg;
        sb      = bx_reg + by_reg;
        wv      = mag(sa);
        hv      = mag(sb);
        is_long = ({2'b00, wv} << 1) > ({2'b00, hv} + ({2'b00, hv} << 1));
        ax2     = ax_reg >>> 1;
        ay2     = ay_reg >>> 1;
        bx2     = bx_reg >>> 1;
        by2     = by_reg >>> 1;
        a2m     = mag(ax2 + ay2);
        b2m     = mag(bx2 + by2);
        if (is_long)
        begin
            if (a2m[0] && wv > MW'(2))
            begin
                ax2 = ax2 + sgn(ax_reg);
                ay2 = ay2 + sgn(ay_reg);
            end
        end
        else if (b2m[0] && hv > MW'(2))
        begin
            bx2 = bx2 + sgn(bx_reg);
            by2 = by2 + sgn(by_reg);
        end
        a2m  = mag(ax2 + ay2);
        b2m  = mag(bx2 + by2);
        sb2  = bx2 + by2;
        m1   = is_long ? PW'(a2m) * PW'(hv) : PW'(b2m) * PW'(a2m);
        m2   = PW'(wv) * PW'(mag(sb - sb2));
        di   = rem_reg - cur_reg;
        di_s = SW'(di);
        p12  = {1'b0, p1_reg} + {1'b0, p2_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_reg <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            cur_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            ax_reg   <= '0;
            ay_reg   <= '0;
            bx_reg   <= '0;
            by_reg   <= '0;
            ax2_reg  <= '0;
            ay2_reg  <= '0;
            bx2_reg  <= '0;
            by2_reg  <= '0;
            long_reg <= 1'b0;
            p1_reg   <= '0;
            p2_reg   <= '0;
        end
        else if (cmd.load)
        begin
            area_reg <= PW'(w_cl) * PW'(h_cl);
            quo_reg  <= task_index;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            cur_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            if (along_w)
            begin
                ax_reg <= SW'(w_cl);
                ay_reg <= '0;
                bx_reg <= '0;
                by_reg <= SW'(h_cl);
            end
            else
            begin
                ax_reg <= '0;
                ay_reg <= SW'(h_cl);
                bx_reg <= SW'(w_cl);
                by_reg <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? PW'(rem_shift - {1'b0, area_reg}) : PW'(rem_shift);
            quo_reg <= {quo_reg[INDEX_BITS-2:0], rem_ge};
            cnt_reg <= cnt_reg + CNW'(1);
        end
        else if (cmd.walk_eval)
        begin
            if (hv == MW'(1))
            begin
                x_reg <= x_reg + sgn(ax_reg) * di_s;
                y_reg <= y_reg + sgn(ay_reg) * di_s;
            end
            else if (wv == MW'(1))
            begin
                x_reg <= x_reg + sgn(bx_reg) * di_s;
                y_reg <= y_reg + sgn(by_reg) * di_s;
            end
            ax2_reg  <= ax2;
            ay2_reg  <= ay2;
            bx2_reg  <= bx2;
            by2_reg  <= by2;
            long_reg <= is_long;
            p1_reg   <= m1;
            p2_reg   <= m2;
        end
        else if (cmd.walk_update)
        begin
            if (long_reg)
            begin
                if (di < p1_reg)
                begin
                    ax_reg <= ax2_reg;
                    ay_reg <= ay2_reg;
                end
                else
                begin
                    cur_reg <= cur_reg + p1_reg;
                    x_reg   <= x_reg + ax2_reg;
                    y_reg   <= y_reg + ay2_reg;
                    ax_reg  <= ax_reg - ax2_reg;
                    ay_reg  <= ay_reg - ay2_reg;
                end
            end
            else if (di < p1_reg)
            begin
                ax_reg <= bx2_reg;
                ay_reg <= by2_reg;
                bx_reg <= ax2_reg;
                by_reg <= ay2_reg;
            end
            else if ({1'b0, di} < p12)
            begin
                cur_reg <= cur_reg + p1_reg;
                x_reg   <= x_reg + bx2_reg;
                y_reg   <= y_reg + by2_reg;
                bx_reg  <= bx_reg - bx2_reg;
                by_reg  <= by_reg - by2_reg;
            end
            else
            begin
                // Third part: jump to the far corner and turn back.
                cur_reg <= PW'(p12 + {1'b0, cur_reg});
                x_reg   <= x_reg + (ax_reg - sgn(ax_reg)) + (bx2_reg - sgn(bx_reg));
                y_reg   <= y_reg + (ay_reg - sgn(ay_reg)) + (by2_reg - sgn(by_reg));
                ax_reg  <= -bx2_reg;
                ay_reg  <= -by2_reg;
                bx_reg  <= -(ax_reg - ax2_reg);
                by_reg  <= -(ay_reg - ay2_reg);
            end
        end
    end

    assign status.div_last = (cnt_reg == CNT_LAST);
    assign status.walk_end = (hv == MW'(1)) || (wv == MW'(1));

    assign outer_index = quo_reg;
    assign m_coord     = x_reg[COORD_BITS-1:0];
    assign n_coord     = y_reg[COORD_BITS-1:0];

endmodule

// ===== hw/rtl/generalized_hilbert_index_to_xy.sv =====
// Top level of the generalized Hilbert index-to-coordinate block.
// Depends on ghix_pkg, ghix_ctrl and ghix_datapath.
//
// Usage: write grid_width (index 0) and grid_height (index 1) through the
// cfg_we / cfg_index / cfg_data port while the block is idle. A write to any
// other index is ignored. Raise start with task_index while busy is low; the
// item is taken at that clock edge and busy rises.
// Each item first goes through a restoring divider by the grid area, one
// quotient bit per cycle, which gives outer_index and the position on the
// curve. The walk then narrows the rectangle level by level: each level
// first forms the split products (ST_WALK_A), then picks the part that
// holds the position (ST_WALK_B). The block is idle in the cycle after
// done and takes no new item before then.
// The result (outer_index, m_coord, n_coord) is valid for the one cycle in
// which done is high; the receiver cannot stall it, so it must take it then.
// Reset sets both grid dimensions to 1 and returns the block to idle.
module generalized_hilbert_index_to_xy #(
    parameter int COORD_BITS = ghix_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = ghix_pkg::INDEX_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ghix_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ghix_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                                start,
    input  logic [INDEX_BITS-1:0]               task_index,
    output logic                                busy,
    output logic                                done,
    output logic [INDEX_BITS-1:0]               outer_index,
    output logic [COORD_BITS-1:0]               m_coord,
    output logic [COORD_BITS-1:0]               n_coord
);
    import ghix_pkg::*;

    logic [CFG_BITS-1:0] grid_width_reg;
    logic [CFG_BITS-1:0] grid_height_reg;
    ghix_cmd_t           cmd;
    ghix_status_t        status;

    // Configuration registers; dimensions are clamped in the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_BITS'(1);
            grid_height_reg <= CFG_BITS'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_GRID_WIDTH)
            begin
                grid_width_reg <= cfg_data;
            end
            else if (cfg_index == REG_GRID_HEIGHT)
            begin
                grid_height_reg <= cfg_data;
            end
        end
    end

    ghix_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    ghix_datapath #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .task_index  (task_index),
        .outer_index (outer_index),
        .m_coord     (m_coord),
        .n_coord     (n_coord)
    );

endmodule

// ===== tb/ghix_checker.sv =====
// Checker for the generalized Hilbert index-to-coordinate block.
// Watches the config, command and result ports, predicts each result and compares.
// Depends on ghix_pkg.
module ghix_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] task_index,
    input  logic        done,
    input  logic [31:0] outer_index,
    input  logic [11:0] m_coord,
    input  logic [11:0] n_coord,
    output int          fail_count,
    output int          pending
);
    import ghix_pkg::*;

    typedef struct packed {
        logic [31:0] outer;
        logic [11:0] m;
        logic [11:0] n;
    } tile_pos_t;

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    tile_pos_t   pos_q[$];

    function automatic longint mag_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint halve(longint v);
        return (v >= 0) ? v / 2 : -((1 - v) / 2);
    endfunction

    function automatic longint clamp_side(logic [12:0] v);
        if (v == 0) return 1;
        if (v > 4096) return 4096;
        return longint'(v);
    endfunction

    // Narrows the rectangle (a, b) until it is one tile thick, tracking the
    // offset of the part that holds position dst.
    function automatic void curve_walk(input longint dst, input longint ax_i,
                                       input longint ay_i, input longint bx_i,
                                       input longint by_i, output longint px,
                                       output longint py);
        longint ax, ay, bx, by, x, y, cur, w, h, dax, day, dbx, dby, di;
        longint ax2, ay2, bx2, by2, nxt, nax, nay;
        bit     stop;
        ax = ax_i; ay = ay_i; bx = bx_i; by = by_i;
        x = 0; y = 0; cur = 0; stop = 0;
        for (int g = 0; g < 64 + 16 * 12 && !stop; g++)
        begin
            w = mag_of(ax + ay);
            h = mag_of(bx + by);
            dax = sign_of(ax); day = sign_of(ay);
            dbx = sign_of(bx); dby = sign_of(by);
            di = dst - cur;
            if (h == 1)
            begin
                x += dax * di; y += day * di; stop = 1;
            end
            else if (w == 1)
            begin
                x += dbx * di; y += dby * di; stop = 1;
            end
            else
            begin
                ax2 = halve(ax); ay2 = halve(ay);
                bx2 = halve(bx); by2 = halve(by);
                if (2 * w > 3 * h)
                begin
                    if ((mag_of(ax2 + ay2) & 1) != 0 && w > 2)
                    begin
                        ax2 += dax; ay2 += day;
                    end
                    nxt = cur + mag_of((ax2 + ay2) * (bx + by));
                    if (cur <= dst && dst < nxt)
                    begin
                        ax = ax2; ay = ay2;
                    end
                    else
                    begin
                        cur = nxt;
                        x += ax2; y += ay2;
                        ax -= ax2; ay -= ay2;
                    end
                end
                else
                begin
                    if ((mag_of(bx2 + by2) & 1) != 0 && h > 2)
                    begin
                        bx2 += dbx; by2 += dby;
                    end
                    nxt = cur + mag_of((bx2 + by2) * (ax2 + ay2));
                    if (cur <= dst && dst < nxt)
                    begin
                        ax = bx2; ay = by2; bx = ax2; by = ay2;
                    end
                    else
                    begin
                        cur = nxt;
                        nxt = cur + mag_of((ax + ay) * ((bx - bx2) + (by - by2)));
                        if (cur <= dst && dst < nxt)
                        begin
                            x += bx2; y += by2;
                            bx -= bx2; by -= by2;
                        end
                        else
                        begin
                            cur = nxt;
                            x += (ax - dax) + (bx2 - dbx);
                            y += (ay - day) + (by2 - dby);
                            nax = -bx2; nay = -by2;
                            bx = -(ax - ax2); by = -(ay - ay2);
                            ax = nax; ay = nay;
                        end
                    end
                end
            end
        end
        px = x;
        py = y;
    endfunction

    function automatic tile_pos_t locate_tile(logic [31:0] idx, logic [12:0] wr,
                                              logic [12:0] hr);
        longint    w, h, area, rem, x, y;
        bit        along_w_ok, along_h_ok;
        tile_pos_t r;
        w = clamp_side(wr);
        h = clamp_side(hr);
        area = w * h;
        r.outer = 32'(longint'(idx) / area);
        rem = longint'(idx) % area;
        along_w_ok = (w % 2 == 0) || (h % 2 == 1);
        along_h_ok = (w % 2 == 1) || (h % 2 == 0);
        if ((w >= h && along_w_ok) || !along_h_ok)
            curve_walk(rem, w, 0, 0, h, x, y);
        else
            curve_walk(rem, 0, h, w, 0, x, y);
        r.m = x[11:0];
        r.n = y[11:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    assign pending = pos_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        tile_pos_t e;
        if (!rst_n)
        begin
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
            fail_count <= 0;
            pos_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_GRID_WIDTH) width_reg <= cfg_data;
                else if (cfg_index == REG_GRID_HEIGHT) height_reg <= cfg_data;
            end
            if (done)
            begin
                if (pos_q.size() == 0)
                begin
                    report_mismatch("result items in excess", 1, 0);
                end
                else
                begin
                    e = pos_q.pop_front();
                    if (outer_index !== e.outer) report_mismatch("outer_index",
                        outer_index, e.outer);
                    if (m_coord !== e.m) report_mismatch("m_coord", m_coord, e.m);
                    if (n_coord !== e.n) report_mismatch("n_coord", n_coord, e.n);
                end
            end
            if (start && !busy)
                pos_q.push_back(locate_tile(task_index, width_reg, height_reg));
        end
    end
endmodule

// ===== tb/tb_generalized_hilbert_index_to_xy.sv =====
// Testbench top for the generalized Hilbert index-to-coordinate block.
// Drives config writes and items, and gives the verdict from ghix_checker.
// Depends on ghix_pkg, ghix_checker and generalized_hilbert_index_to_xy.
module tb_generalized_hilbert_index_to_xy;
    import ghix_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        start;
    logic [31:0] task_index;
    logic        busy;
    logic        done;
    logic [31:0] outer_index;
    logic [11:0] m_coord;
    logic [11:0] n_coord;
    int          fail_count;
    int          pending;
    int          items_sent;
    int          results_seen;
    int          phases_run;
    int          idle_cycles;

    // The watchdog gives up after this many cycles with no item moving.
    localparam int STALL_LIMIT = 20000;

    // Register indexes that the block does not implement.
    localparam logic [1:0] REG_SPARE_LO = 2'd2;
    localparam logic [1:0] REG_SPARE_HI = 2'd3;

    generalized_hilbert_index_to_xy u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .task_index(task_index),
        .busy(busy), .done(done), .outer_index(outer_index),
        .m_coord(m_coord), .n_coord(n_coord)
    );

    ghix_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy),
        .task_index(task_index), .done(done), .outer_index(outer_index),
        .m_coord(m_coord), .n_coord(n_coord), .fail_count(fail_count),
        .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Count result items, and watch for a hang: any accepted item or result
    // item resets the idle counter.
    always @(posedge clk)
    begin
        if (done) results_seen++;
        if ((start && !busy) || done || !rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Most gaps are short; now and then a long one lands on a random phase
    // of the divider or the walk.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [12:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold start high with the item until an edge sees busy low.
    task automatic send_item(logic [31:0] value);
        int gap;
        start      <= 1'b1;
        task_index <= value;
        do @(posedge clk); while (busy);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let every result come back, then wait a while longer so that a config
    // write never lands on a block at work.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (results_seen != items_sent) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic set_grid(logic [12:0] w, logic [12:0] h);
        drain();
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        phases_run++;
    endtask

    // A phase mixes indices that land inside the first few grid passes with
    // indices spread over the full 32-bit range.
    task automatic run_phase(logic [12:0] w, logic [12:0] h, int count);
        longint area;
        set_grid(w, h);
        area = ((w == 0) ? 1 : ((w > 4096) ? 4096 : w)) *
               ((h == 0) ? 1 : ((h > 4096) ? 4096 : h));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) != 0)
                send_item($urandom_range(0, 32'(area * 3 - 1)));
            else
                send_item($urandom());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        start        = 1'b0;
        task_index   = '0;
        items_sent   = 0;
        results_seen = 0;
        phases_run   = 0;
        idle_cycles  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The reset grid is one tile, so every index maps to
        // the origin and the outer index equals the task index.
        send_item(32'd0);
        send_item(32'hFFFF_FFFF);
        send_item(32'hAAAA_AAAA);
        send_item(32'h5555_5555);

        // A zero dimension acts as one; writes to the unused indexes must
        // leave the grid alone.
        set_grid(13'd0, 13'd5);
        write_reg(REG_SPARE_LO, 13'h1FFF);
        write_reg(REG_SPARE_HI, 13'h1555);
        send_item(32'd4);
        send_item(32'd5);

        // Oversized sides clamp to 4096; both extremes of the index.
        set_grid(13'h1FFF, 13'd4096);
        send_item(32'd0);
        send_item(32'hFFFF_FFFF);
        send_item(32'h00FF_FFFF);
        send_item(32'h0100_0000);

        // A wide grid (7 by 2) starts along its height and a tall one (2 by 7) along its width,
        // both with the three-part split; odd by odd and even by even both start along the width.
        set_grid(13'd7, 13'd2);
        for (int i = 0; i < 14; i++) send_item(32'(i));
        set_grid(13'd2, 13'd7);
        send_item(32'd13);
        send_item(32'd14);
        set_grid(13'd5, 13'd5);
        send_item(32'd24);
        set_grid(13'd6, 13'd4);
        send_item(32'd23);

        // Random part over a spread of grids, the extremes among them.
        run_phase(13'd1, 13'd1, 20);
        run_phase(13'd4096, 13'd1, 30);
        run_phase(13'd1, 13'd4096, 30);
        run_phase(13'd4096, 13'd4096, 30);
        run_phase(13'd3, 13'd8, 40);
        run_phase(13'd9, 13'd4, 40);
        for (int p = 0; p < 13; p++)
            run_phase(13'($urandom_range(0, 13'h1FFF) >> $urandom_range(0, 12)),
                      13'($urandom_range(0, 13'h1FFF) >> $urandom_range(0, 12)), 20);

        drain();
        $display("covered %0d items over %0d grid settings, clamped and unused",
                 items_sent, phases_run);
        $display("register writes included, with random gaps between items");
        if (fail_count == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived", fail_count, pending);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/ghix_pkg.sv
hw/rtl/ghix_ctrl.sv
hw/rtl/ghix_datapath.sv
hw/rtl/generalized_hilbert_index_to_xy.sv
tb/ghix_checker.sv
tb/tb_generalized_hilbert_index_to_xy.sv
